// ----- rtl/core/iss_pkg.sv -----
// iss_pkg: shared types and constants for the indexed sequence store.
// Used by iss_cell and indexed_sequence_store; no dependencies.
package iss_pkg;

	localparam int CAPACITY = 16;
	localparam int DATA_W   = 32;
	localparam int POS_W    = 5;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

	typedef enum logic [1:0] {
		MODE_READ   = 2'd0,
		MODE_WRITE  = 2'd1,
		MODE_INSERT = 2'd2,
		MODE_DELETE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_INDEX = 2'd3
	} status_t;

	// Broadcast to every cell; strobes are only set for a successful transaction
	typedef struct packed {
		logic             wr;
		logic             ins;
		logic             del;
		logic [POS_W-1:0] pos;
	} cell_cmd_t;

endpackage

// ----- rtl/core/iss_cell.sv -----
// iss_cell: one list slot; holds one element and shifts with its neighbours.
// Depends on iss_pkg.
module iss_cell (
	input  logic                                   clk,
	input  logic [iss_pkg::IDX_W-1:0]              idx,
	input  iss_pkg::cell_cmd_t                     cmd,
	input  logic signed [iss_pkg::DATA_W-1:0]      data_in,
	input  logic signed [iss_pkg::DATA_W-1:0]      left_val,
	input  logic signed [iss_pkg::DATA_W-1:0]      right_val,
	output logic signed [iss_pkg::DATA_W-1:0]      val,
	output logic signed [iss_pkg::DATA_W-1:0]      rd_tap
);

	logic signed [iss_pkg::DATA_W-1:0] val_q;
	logic signed [iss_pkg::DATA_W-1:0] val_d;
	logic [iss_pkg::POS_W-1:0]         idx_ext;
	logic                              hit;
	logic                              above;

	assign idx_ext = iss_pkg::POS_W'(idx);
	assign hit     = (idx_ext == cmd.pos);
	assign above   = (idx_ext > cmd.pos);

	always_comb begin
		val_d = val_q;
		if (cmd.wr && hit) begin
			val_d = data_in;
		end else if (cmd.ins) begin
			if (hit) begin
				val_d = data_in;
			end else if (above) begin
				val_d = left_val;
			end
		end else if (cmd.del && (hit || above)) begin
			// slots past the old end pick up stale data; never read
			val_d = right_val;
		end
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

	assign val    = val_q;
	assign rd_tap = hit ? val_q : '0;

endmodule

// ----- rtl/core/indexed_sequence_store.sv -----
// indexed_sequence_store: fixed-capacity ordered list built as a row of cells.
// Result: registered when the request transaction is accepted.
// Throughput: one transaction per cycle unless held off; insert and delete shift every cell at once.
// Request is held off only while an earlier result is stalled.
// Reset clears the element count and the result valid; element storage is not cleared.
// Depends on iss_pkg and iss_cell.
module indexed_sequence_store (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   req_valid,
	output logic                                   req_stall,
	input  logic [1:0]                             mode,
	input  logic [iss_pkg::POS_W-1:0]              position,
	input  logic signed [iss_pkg::DATA_W-1:0]      data_in,
	output logic                                   rsp_valid,
	input  logic                                   rsp_stall,
	output logic signed [iss_pkg::DATA_W-1:0]      data_out,
	output logic [iss_pkg::CNT_W-1:0]              count,
	output logic [1:0]                             status
);

	logic [iss_pkg::CNT_W-1:0]          n_q;
	logic [iss_pkg::CNT_W-1:0]          n_d;
	logic                               rsp_valid_q;
	logic signed [iss_pkg::DATA_W-1:0]  data_out_q;
	logic [iss_pkg::CNT_W-1:0]          count_q;
	iss_pkg::status_t                   status_q;
	iss_pkg::status_t                   status_d;
	iss_pkg::mode_t                     mode_r;
	iss_pkg::cell_cmd_t                 cmd;
	logic                               accept;
	logic [iss_pkg::CMP_W-1:0]          pos_c;
	logic [iss_pkg::CMP_W-1:0]          n_c;
	logic signed [iss_pkg::DATA_W-1:0]  rd_val;
	logic signed [iss_pkg::DATA_W-1:0]  rd_d;

	logic signed [iss_pkg::DATA_W-1:0]  cell_val [iss_pkg::CAPACITY];
	logic signed [iss_pkg::DATA_W-1:0]  cell_rd  [iss_pkg::CAPACITY];

	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign mode_r    = iss_pkg::mode_t'(mode);
	assign pos_c     = iss_pkg::CMP_W'(position);
	assign n_c       = iss_pkg::CMP_W'(n_q);

	always_comb begin
		status_d = iss_pkg::ST_OK;
		n_d      = n_q;
		cmd.wr   = 1'b0;
		cmd.ins  = 1'b0;
		cmd.del  = 1'b0;
		cmd.pos  = position;
		case (mode_r)
			iss_pkg::MODE_READ: begin
				if (pos_c >= n_c) status_d = iss_pkg::ST_INDEX;
			end
			iss_pkg::MODE_WRITE: begin
				if (pos_c >= n_c) status_d = iss_pkg::ST_INDEX;
				else cmd.wr = accept;
			end
			iss_pkg::MODE_INSERT: begin
				if (n_c == iss_pkg::CMP_W'(iss_pkg::CAPACITY)) begin
					status_d = iss_pkg::ST_FULL;
				end else if (pos_c > n_c) begin
					status_d = iss_pkg::ST_INDEX;
				end else begin
					cmd.ins = accept;
					n_d     = n_q + 1'b1;
				end
			end
			iss_pkg::MODE_DELETE: begin
				if (n_q == '0) begin
					status_d = iss_pkg::ST_EMPTY;
				end else if (pos_c >= n_c) begin
					status_d = iss_pkg::ST_INDEX;
				end else begin
					cmd.del = accept;
					n_d     = n_q - 1'b1;
				end
			end
			default: status_d = iss_pkg::ST_INDEX;
		endcase
	end

	for (genvar i = 0; i < iss_pkg::CAPACITY; i++) begin : g_cell
		logic signed [iss_pkg::DATA_W-1:0] left_val;
		logic signed [iss_pkg::DATA_W-1:0] right_val;

		if (i == 0) begin : g_first
			assign left_val = data_in;
		end else begin : g_mid_l
			assign left_val = cell_val[i-1];
		end
		if (i == iss_pkg::CAPACITY - 1) begin : g_last
			assign right_val = '0;
		end else begin : g_mid_r
			assign right_val = cell_val[i+1];
		end

		iss_cell u_cell (
			.clk       (clk),
			.idx       (iss_pkg::IDX_W'(i)),
			.cmd       (cmd),
			.data_in   (data_in),
			.left_val  (left_val),
			.right_val (right_val),
			.val       (cell_val[i]),
			.rd_tap    (cell_rd[i])
		);
	end

	// at most one tap is non-zero
	always_comb begin
		rd_val = '0;
		for (int i = 0; i < iss_pkg::CAPACITY; i++) begin
			rd_val = rd_val | cell_rd[i];
		end
	end

	assign rd_d = (mode_r == iss_pkg::MODE_READ && status_d == iss_pkg::ST_OK) ? rd_val : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				n_q         <= n_d;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_out_q <= rd_d;
			count_q    <= n_d;
			status_q   <= status_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign data_out  = data_out_q;
	assign count     = count_q;
	assign status    = status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= iss_pkg::CNT_W'(iss_pkg::CAPACITY))
		else $error("element count above capacity");

	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (count_q == n_q))
		else $error("result count differs from stored count");

	a_fail_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && status_d != iss_pkg::ST_OK) |=> (n_q == $past(n_q)))
		else $error("failed transaction changed the count");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode_r == iss_pkg::MODE_INSERT && status_d == iss_pkg::ST_OK)
		|=> (n_q == $past(n_q) + 1'b1))
		else $error("insert did not grow the list");

	a_stall_needs_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid_q)
		else $error("request held off with no pending result");

endmodule
